>>> hdl/gir_pkg.sv
`timescale 1ns / 1ps
// group id registry table: shared types and codes
// no dependencies

package gir_pkg;

  localparam int MAX_GROUPS_DEF = 64;
  localparam int MAXG_W = 7;
  localparam logic [MAXG_W-1:0] MAXG_RESET = 7'd64;
  localparam int KEY_W = 64;

  // operation codes
  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_STOP   = 3'd2;
  localparam logic [2:0] OP_RESUME = 3'd3;
  localparam logic [2:0] OP_LOOKUP = 3'd4;

  // status codes
  localparam logic [2:0] ST_DONE        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd1;
  localparam logic [2:0] ST_EXISTS      = 3'd2;
  localparam logic [2:0] ST_FULL        = 3'd3;
  localparam logic [2:0] ST_NO_REPLICAS = 3'd4;
  localparam logic [2:0] ST_NOT_STOPPED = 3'd5;

  // group state codes
  localparam logic [1:0] GS_ABSENT  = 2'd0;
  localparam logic [1:0] GS_ACTIVE  = 2'd1;
  localparam logic [1:0] GS_STOPPED = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_EXEC
  } seq_state_t;

endpackage

>>> hdl/gir_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies

module gir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/group_id_registry_table.sv
`timescale 1ns / 1ps
// group id registry table: top level with scan sequencer and entry store
// depends on gir_pkg and gir_ram
//
// channel | signals                                      | direction
// in      | in_valid, in_stall, operation, group_id,     | into block
//         | replica_count                                |
// out     | out_valid, out_stall, ok, status,            | out of block
//         | group_state, group_count, active_count       |
// cfg     | cfg_valid, cfg_ready, max_groups             | into block
//
// a transaction walks the one read port of the entry ram over every slot
// in S_SCAN, then S_LAST finishes the last compare and S_EXEC applies the
// update. after reset a clearing pass writes every slot, with in_stall
// high; cfg writes are taken at any time.
// a new transaction is taken while a result waits in the output register;
// the update cycle waits while out_stall holds that register.

module group_id_registry_table
  import gir_pkg::*;
#(
  parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        operation,
  input  logic [KEY_W-1:0]  group_id,
  input  logic [7:0]        replica_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              ok,
  output logic [2:0]        status,
  output logic [1:0]        group_state,
  output logic [6:0]        group_count,
  output logic [6:0]        active_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MAXG_W-1:0] max_groups
);

  localparam int IDX_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CNT_RAW = $clog2(MAX_GROUPS + 1);
  localparam int CNT_W = (CNT_RAW > 7) ? CNT_RAW : 7;
  localparam int RAM_W = KEY_W + 2;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_GROUPS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_GROUPS);

  seq_state_t state, state_next;

  logic [IDX_W-1:0]  scan_addr;
  logic              chk_valid;
  logic [IDX_W-1:0]  chk_idx;
  logic [2:0]        op;
  logic [KEY_W-1:0]  key;
  logic              reps_zero;
  logic              hit;
  logic              hit_stopped;
  logic [IDX_W-1:0]  hit_idx;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [CNT_W-1:0]  held_cnt, held_next;
  logic [CNT_W-1:0]  live_cnt, live_next;
  logic [MAXG_W-1:0] maxg;

  logic              ok_q;
  logic [2:0]        status_q;
  logic [1:0]        gs_q;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic [RAM_W-1:0]  ram_rdata;
  logic              rd_valid;
  logic              rd_stopped;
  logic [KEY_W-1:0]  rd_key;

  logic              exec_go;
  logic              ex_ok;
  logic [2:0]        ex_status;
  logic [1:0]        ex_gs;
  logic              ex_we;
  logic [IDX_W-1:0]  ex_waddr;
  logic [RAM_W-1:0]  ex_wdata;

  assign rd_valid   = ram_rdata[RAM_W-1];
  assign rd_stopped = ram_rdata[RAM_W-2];
  assign rd_key     = ram_rdata[KEY_W-1:0];

  assign exec_go   = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  gir_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_GROUPS)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = scan_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == S_EXEC) && exec_go && ex_we;
      ram_waddr = ex_waddr;
      ram_wdata = ex_wdata;
    end
  end

  // operation decision
  always_comb begin
    ex_ok     = 1'b0;
    ex_status = ST_DONE;
    ex_gs     = hit ? (hit_stopped ? GS_STOPPED : GS_ACTIVE) : GS_ABSENT;
    held_next = held_cnt;
    live_next = live_cnt;
    ex_we     = 1'b0;
    ex_waddr  = hit_idx;
    ex_wdata  = {1'b1, hit_stopped, key};
    if (op == OP_CREATE) begin
      priority if (reps_zero) begin
        ex_status = ST_NO_REPLICAS;
      end else if (hit) begin
        ex_status = ST_EXISTS;
      end else if (held_cnt >= CNT_W'(maxg) || held_cnt >= CNT_MAX || !free_found) begin
        ex_status = ST_FULL;
      end else begin
        ex_ok     = 1'b1;
        ex_gs     = GS_ACTIVE;
        ex_we     = 1'b1;
        ex_waddr  = free_idx;
        ex_wdata  = {1'b1, 1'b0, key};
        held_next = held_cnt + 1'b1;
        live_next = live_cnt + 1'b1;
      end
    end else if (!hit) begin
      ex_status = ST_NOT_FOUND;
    end else begin
      unique case (op)
        OP_REMOVE: begin
          ex_ok    = 1'b1;
          ex_gs    = GS_ABSENT;
          ex_we    = 1'b1;
          ex_wdata = '0;
          if (!hit_stopped && live_cnt != '0) begin
            live_next = live_cnt - 1'b1;
          end
          if (held_cnt != '0) begin
            held_next = held_cnt - 1'b1;
          end
        end
        OP_STOP: begin
          ex_ok    = 1'b1;
          ex_gs    = GS_STOPPED;
          ex_we    = !hit_stopped;
          ex_wdata = {1'b1, 1'b1, key};
          if (!hit_stopped && live_cnt != '0) begin
            live_next = live_cnt - 1'b1;
          end
        end
        OP_RESUME: begin
          ex_gs = GS_ACTIVE;
          if (hit_stopped) begin
            ex_ok     = 1'b1;
            ex_we     = 1'b1;
            ex_wdata  = {1'b1, 1'b0, key};
            live_next = live_cnt + 1'b1;
          end else begin
            ex_status = ST_NOT_STOPPED;
          end
        end
        default: begin
          ex_ok = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (scan_addr == LAST_IDX) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_addr == LAST_IDX) state_next = S_LAST;
      end
      S_LAST: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr  <= '0;
      chk_valid  <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      held_cnt   <= '0;
      live_cnt   <= '0;
      maxg       <= MAXG_RESET;
      out_valid  <= 1'b0;
    end else begin
      chk_valid <= (state == S_SCAN);
      if (state == S_CLEAR || state == S_SCAN) begin
        scan_addr <= (scan_addr == LAST_IDX) ? '0 : scan_addr + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        maxg <= max_groups;
      end
      if (state == S_IDLE && in_valid) begin
        hit        <= 1'b0;
        free_found <= 1'b0;
      end
      if (chk_valid) begin
        if (rd_valid && rd_key == key) begin
          hit <= 1'b1;
        end
        if (!rd_valid && !free_found) begin
          free_found <= 1'b1;
        end
      end
      if (state == S_EXEC && exec_go) begin
        held_cnt  <= held_next;
        live_cnt  <= live_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= scan_addr;
    if (state == S_IDLE && in_valid) begin
      op        <= operation;
      key       <= group_id;
      reps_zero <= (replica_count == 8'd0);
    end
    if (chk_valid) begin
      if (rd_valid && rd_key == key) begin
        hit_idx     <= chk_idx;
        hit_stopped <= rd_stopped;
      end
      if (!rd_valid && !free_found) begin
        free_idx <= chk_idx;
      end
    end
    if (state == S_EXEC && exec_go) begin
      ok_q     <= ex_ok;
      status_q <= ex_status;
      gs_q     <= ex_gs;
    end
  end

  assign ok           = ok_q;
  assign status       = status_q;
  assign group_state  = gs_q;
  assign group_count  = held_cnt[6:0];
  assign active_count = live_cnt[6:0];

`ifndef SYNTHESIS
  a_live_le_held: assert property (@(posedge clk) disable iff (rst)
    live_cnt <= held_cnt)
    else $error("active count above group count");

  a_held_le_max: assert property (@(posedge clk) disable iff (rst)
    held_cnt <= CNT_MAX)
    else $error("group count above table size");

  a_ok_matches_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ok == (status == ST_DONE)))
    else $error("ok and status disagree");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_SCAN && scan_addr == '0))
    else $error("scan did not start at slot zero");

  a_removed_is_absent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ok && $past(op) == OP_REMOVE && $rose(out_valid))
      |-> group_state == GS_ABSENT)
    else $error("removed group not reported absent");
`endif

endmodule

>>> dv/group_id_registry_table_tb.sv
`timescale 1ns / 1ps
// testbench for group_id_registry_table: directed and random create/remove/stop/resume/lookup
// traffic, predicted in-bench and checked reply by reply; depends on gir_pkg and the block

module group_id_registry_table_tb;
  import gir_pkg::*;

  localparam logic [2:0] OP_UNUSED_5 = 3'd5;
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int POOL_SIZE = 72;
  localparam int LONG_HOLD_CYCLES = 700;
  localparam logic [63:0] KEY_ZERO = 64'h0;
  localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] KEY_ALT_A = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [63:0] KEY_ALT_5 = 64'h5555_5555_5555_5555;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] id;
    logic [7:0]  reps;
  } registry_op_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] status;
    logic [1:0] gstate;
    logic [6:0] groups;
    logic [6:0] active;
  } registry_reply_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  operation = OP_LOOKUP;
  logic [63:0] group_id = '0;
  logic [7:0]  replica_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        ok;
  logic [2:0]  status;
  logic [1:0]  group_state;
  logic [6:0]  group_count;
  logic [6:0]  active_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  max_groups = MAXG_RESET;

  registry_op_t    pending_ops[$];
  registry_reply_t predicted_replies[$];
  logic [63:0]     id_pool[POOL_SIZE];

  // predictor copy of the table
  bit         group_stopped[bit [63:0]];
  int         held_groups = 0;
  int         live_groups = 0;
  int         peak_held = 0;
  logic [6:0] group_limit = MAXG_RESET;

  int burst_left = 0;
  int gap_left = 0;
  int accepted_n = 0;
  int checked_n = 0;
  int mismatch_n = 0;
  int unsigned cycle_n = 0;
  int stall_mode = 0;
  int seg_left = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;

  group_id_registry_table dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .group_id(group_id),
    .replica_count(replica_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ok(ok),
    .status(status),
    .group_state(group_state),
    .group_count(group_count),
    .active_count(active_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .max_groups(max_groups)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic registry_reply_t registry_apply(input logic [2:0] op,
                                                     input logic [63:0] id,
                                                     input logic [7:0] reps);
    registry_reply_t r;
    int cap;
    bit held;
    held = group_stopped.exists(id);
    cap = (group_limit > MAX_GROUPS_DEF) ? MAX_GROUPS_DEF : int'(group_limit);
    r.ok = 1'b0;
    r.status = ST_DONE;
    if (op == OP_CREATE) begin
      if (reps == 8'd0) begin
        r.status = ST_NO_REPLICAS;
      end else if (held) begin
        r.status = ST_EXISTS;
      end else if (held_groups >= cap) begin
        r.status = ST_FULL;
      end else begin
        group_stopped[id] = 1'b0;
        held_groups++;
        live_groups++;
        r.ok = 1'b1;
      end
    end else if (!held) begin
      r.status = ST_NOT_FOUND;
    end else begin
      case (op)
        OP_REMOVE: begin
          if (!group_stopped[id]) live_groups--;
          group_stopped.delete(id);
          held_groups--;
          r.ok = 1'b1;
        end
        OP_STOP: begin
          if (!group_stopped[id]) begin
            group_stopped[id] = 1'b1;
            live_groups--;
          end
          r.ok = 1'b1;
        end
        OP_RESUME: begin
          if (group_stopped[id]) begin
            group_stopped[id] = 1'b0;
            live_groups++;
            r.ok = 1'b1;
          end else begin
            r.status = ST_NOT_STOPPED;
          end
        end
        default: begin
          r.ok = 1'b1;
        end
      endcase
    end
    if (!group_stopped.exists(id)) r.gstate = GS_ABSENT;
    else r.gstate = group_stopped[id] ? GS_STOPPED : GS_ACTIVE;
    r.groups = held_groups[6:0];
    r.active = live_groups[6:0];
    if (held_groups > peak_held) peak_held = held_groups;
    return r;
  endfunction

  // driver: bursts with random gaps, payload held while stalled
  always @(posedge clk) begin
    registry_op_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_replies.push_back(registry_apply(operation, group_id, replica_count));
        accepted_n++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0 || pending_ops.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          nxt = pending_ops.pop_front();
          in_valid <= 1'b1;
          operation <= nxt.op;
          group_id <= nxt.id;
          replica_count <= nxt.reps;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 100);
          end
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_left <= LONG_HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        seg_left = $urandom_range(20, 300);
      end else begin
        seg_left--;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    registry_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_replies.size() == 0) begin
        mismatch_n++;
        if (mismatch_n <= 10)
          $display("unexpected transaction: ok=%0d status=%0d state=%0d groups=%0d active=%0d",
                   ok, status, group_state, group_count, active_count);
      end else begin
        want = predicted_replies.pop_front();
        if (ok !== want.ok || status !== want.status || group_state !== want.gstate ||
            group_count !== want.groups || active_count !== want.active) begin
          mismatch_n++;
          if (mismatch_n <= 10) begin
            $display("transaction %0d: exp ok=%0d status=%0d state=%0d groups=%0d active=%0d",
                     checked_n, want.ok, want.status, want.gstate, want.groups,
                     want.active);
            $display("transaction %0d: got ok=%0d status=%0d state=%0d groups=%0d active=%0d",
                     checked_n, ok, status, group_state, group_count, active_count);
          end
        end
        checked_n++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_op(input logic [2:0] op, input logic [63:0] id, input logic [7:0] reps);
    registry_op_t item;
    item.op = op;
    item.id = id;
    item.reps = reps;
    pending_ops.push_back(item);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || predicted_replies.size() != 0);
  endtask

  task automatic write_limit(input logic [6:0] lim);
    @(posedge clk);
    cfg_valid <= 1'b1;
    max_groups <= lim;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    group_limit = lim;
    @(negedge clk);
  endtask

  function automatic registry_op_t random_op(input int span, input int create_pct,
                                             input int remove_pct);
    registry_op_t item;
    int r;
    r = $urandom_range(0, 99);
    if (r < create_pct) item.op = OP_CREATE;
    else if (r < create_pct + remove_pct) item.op = OP_REMOVE;
    else begin
      r = $urandom_range(0, 19);
      if (r < 6) item.op = OP_STOP;
      else if (r < 12) item.op = OP_RESUME;
      else if (r < 17) item.op = OP_LOOKUP;
      else item.op = 3'($urandom_range(OP_UNUSED_5, OP_UNUSED_7));
    end
    r = $urandom_range(0, 99);
    if (r < 88) item.id = id_pool[$urandom_range(0, span - 1)];
    else if (r < 96) item.id = {$urandom, $urandom};
    else item.id = $urandom_range(0, 1) ? KEY_ONES : KEY_ZERO;
    item.reps = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    return item;
  endfunction

  task automatic run_phase(input logic [6:0] lim, input int n, input int span,
                           input int create_pct, input int remove_pct, input bit with_hold);
    write_limit(lim);
    repeat (n) pending_ops.push_back(random_op(span, create_pct, remove_pct));
    if (with_hold) hold_req = 1'b1;
    wait_idle();
  endtask

  initial begin
    foreach (id_pool[i]) id_pool[i] = {$urandom, $urandom};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table, replica and state edge cases at the reset limit
    queue_op(OP_LOOKUP, KEY_ZERO, 8'd1);
    queue_op(OP_REMOVE, KEY_ZERO, 8'd1);
    queue_op(OP_CREATE, KEY_ZERO, 8'd0);
    queue_op(OP_CREATE, KEY_ZERO, 8'd255);
    queue_op(OP_CREATE, KEY_ZERO, 8'd1);
    queue_op(OP_CREATE, KEY_ONES, 8'h80);
    queue_op(OP_RESUME, KEY_ONES, 8'd0);
    queue_op(OP_STOP, KEY_ONES, 8'd0);
    queue_op(OP_STOP, KEY_ONES, 8'd0);
    queue_op(OP_LOOKUP, KEY_ONES, 8'd0);
    queue_op(OP_RESUME, KEY_ONES, 8'd0);
    queue_op(OP_STOP, KEY_ONES, 8'd0);
    queue_op(OP_REMOVE, KEY_ONES, 8'd0);
    queue_op(OP_REMOVE, KEY_ZERO, 8'd0);
    queue_op(OP_CREATE, KEY_ALT_A, 8'h7F);
    queue_op(OP_UNUSED_5, KEY_ALT_A, 8'd0);
    queue_op(OP_UNUSED_6, KEY_ALT_5, 8'hFF);
    queue_op(OP_UNUSED_7, KEY_ALT_A, 8'd0);
    queue_op(OP_REMOVE, KEY_ALT_A, 8'd0);
    wait_idle();

    // single-slot table
    write_limit(7'd1);
    queue_op(OP_CREATE, KEY_ALT_A, 8'd1);
    queue_op(OP_CREATE, KEY_ALT_5, 8'd3);
    queue_op(OP_REMOVE, KEY_ALT_A, 8'd0);
    queue_op(OP_CREATE, KEY_ALT_5, 8'd3);
    wait_idle();

    // zero limit refuses creates but keeps entries
    write_limit(7'd0);
    queue_op(OP_CREATE, KEY_ALT_A, 8'd2);
    queue_op(OP_CREATE, KEY_ALT_5, 8'd0);
    queue_op(OP_CREATE, KEY_ALT_5, 8'd2);
    queue_op(OP_STOP, KEY_ALT_5, 8'd0);
    queue_op(OP_REMOVE, KEY_ALT_5, 8'd0);
    wait_idle();

    run_phase(7'd64, 220, POOL_SIZE, 50, 10, 1'b1);
    run_phase(7'd127, 120, POOL_SIZE, 30, 15, 1'b0);
    run_phase(7'd1, 120, POOL_SIZE, 15, 45, 1'b0);
    run_phase(7'd0, 40, POOL_SIZE, 40, 10, 1'b0);
    run_phase(7'd3, 130, 6, 35, 20, 1'b0);
    run_phase(7'($urandom_range(2, 63)), 120, POOL_SIZE, 35, 15, 1'b0);

    repeat (3 * MAX_GROUPS_DEF) @(negedge clk);
    mismatch_n += predicted_replies.size();
    $display("%0d transactions checked under limits 0, 1, 3, 64, 127 and one random",
             checked_n);
    $display("peak %0d groups held", peak_held);
    if (mismatch_n == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/gir_pkg.sv
hdl/gir_ram.sv
hdl/group_id_registry_table.sv
dv/group_id_registry_table_tb.sv
